FILE: hw/rtl/bmff_pkg.sv
// Shared types, constants and sizes for the bitmap find-first block.
package bmff_pkg;

	localparam int NUM_BYTES = 64;
	localparam int BYTE_W    = 8;
	localparam int IDX_W     = 9;
	localparam int OP_W      = 3;
	localparam int BYTE_AW   = (NUM_BYTES > 1) ? $clog2(NUM_BYTES) : 1;
	localparam int CNT_W     = $clog2(NUM_BYTES + 1);
	localparam int POS_W     = BYTE_AW + 3;

	typedef enum logic [OP_W-1:0] {
		OP_SET       = 3'd0,
		OP_CLEAR     = 3'd1,
		OP_READ      = 3'd2,
		OP_FIND_ONE  = 3'd3,
		OP_FIND_ZERO = 3'd4,
		OP_FILL      = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_MODIFY,
		ST_SCAN,
		ST_FILL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic rd_idx;
		logic modify;
		logic scan;
		logic fill;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic scan_hit;
		logic scan_end;
	} sts_t;

	localparam logic [BYTE_W-1:0] CLEAR_MASKS [8] = '{
		8'd254, 8'd253, 8'd251, 8'd247, 8'd239, 8'd223, 8'd191, 8'd127
	};

endpackage

FILE: hw/rtl/bitmap_with_find_first_core.sv
// Bitmap with find-first-set/clear: top level joining controller and datapath.
//
// Input channel (in_valid/in_ready) takes one request beat: operation, bit_index
// and fill_value. Output channel (out_valid/out_ready) returns exactly one result
// beat per request: bit_value, found_index and found.
// The map is 64 bytes in a single-port-read RAM; bit i lives in byte i/8, bit i%8.
// One request is in work at a time; the next is taken once the previous result
// has moved into the output register, even if that beat is still waiting.
// Steps from input beat to output valid:
//   set, clear, read : read the byte, modify or sample, hand off
//   fill, unused ops : no RAM read; a fill drops all valid bits at once, no RAM sweep
//   find one / zero  : one byte read per cycle from the RAM read port; stops
//                      early at the first matching byte, else at the last byte.
// Reset clears all valid bits and the fill value, so the map reads as all zeros
// at once. A stalled out_ready holds the output beat and the next result waits
// in the controller until the output register frees up.
module bitmap_with_find_first_core import bmff_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [OP_W-1:0]  operation,
	input  logic [IDX_W-1:0] bit_index,
	input  logic             fill_value,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             bit_value,
	output logic [IDX_W-1:0] found_index,
	output logic             found
);

	cmd_t cmd;
	sts_t sts;

	bmff_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.operation(operation),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	bmff_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.operation  (operation),
		.bit_index  (bit_index),
		.fill_value (fill_value),
		.cmd        (cmd),
		.sts        (sts),
		.bit_value  (bit_value),
		.found_index(found_index),
		.found      (found)
	);

endmodule

FILE: hw/rtl/bmff_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bmff_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hw/rtl/bmff_ctrl.sv
// Controller state machine: sequences access, scan, fill and result beats.
module bmff_ctrl import bmff_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [OP_W-1:0] operation,
	output logic            out_valid,
	input  logic            out_ready,
	output cmd_t            cmd,
	input  sts_t            sts
);

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (operation)
						OP_SET, OP_CLEAR, OP_READ: state_d = ST_FETCH;
						OP_FIND_ONE, OP_FIND_ZERO: state_d = ST_SCAN;
						OP_FILL:                   state_d = ST_FILL;
						default:                   state_d = ST_DONE;
					endcase
				end
			end
			ST_FETCH:  state_d = ST_MODIFY;
			ST_MODIFY: state_d = ST_DONE;
			ST_SCAN: begin
				if (sts.scan_hit || sts.scan_end) begin
					state_d = ST_DONE;
				end
			end
			ST_FILL: state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_FETCH:  cmd.rd_idx = 1'b1;
			ST_MODIFY: cmd.modify = 1'b1;
			ST_SCAN:   cmd.scan   = 1'b1;
			ST_FILL:   cmd.fill   = 1'b1;
			ST_DONE:   cmd.out_load = !out_valid_q || out_ready;
			default: begin
				cmd      = '0;
				in_ready = 1'b0;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

FILE: hw/rtl/bmff_dp.sv
// Datapath: byte store with valid bits, modify logic, scan unit and result registers.
module bmff_dp import bmff_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [OP_W-1:0]  operation,
	input  logic [IDX_W-1:0] bit_index,
	input  logic             fill_value,
	input  cmd_t             cmd,
	output sts_t             sts,
	output logic             bit_value,
	output logic [IDX_W-1:0] found_index,
	output logic             found
);

	logic [OP_W-1:0]    op_q;
	logic [IDX_W-1:0]   idx_q;
	logic               fillv_q;
	logic               fill_q;
	logic [NUM_BYTES-1:0] vld_q;
	logic [CNT_W-1:0]   addr_q;
	logic               chk_s1;
	logic               vld_s1;
	logic [BYTE_AW-1:0] b_s1;
	logic               res_bit_q;
	logic [IDX_W-1:0]   res_idx_q;
	logic               res_found_q;
	logic               bit_value_q;
	logic [IDX_W-1:0]   found_index_q;
	logic               found_q;

	logic [BYTE_AW-1:0] idx_byte;
	logic [2:0]         idx_bit;
	logic               in_range;
	logic               issue;
	logic               re;
	logic [BYTE_AW-1:0] raddr;
	logic [BYTE_W-1:0]  rdata;
	logic [BYTE_W-1:0]  eff;
	logic               is_rmw;
	logic               we;
	logic [BYTE_W-1:0]  wdata;
	logic               want;
	logic [BYTE_W-1:0]  match_bits;
	logic               match;
	logic [2:0]         first_k;
	logic [POS_W-1:0]   pos;

	assign idx_byte = BYTE_AW'(idx_q[IDX_W-1:3]);
	assign idx_bit  = idx_q[2:0];
	assign in_range = int'(idx_q[IDX_W-1:3]) < NUM_BYTES;

	// Scan issues one read per cycle until the last byte has gone out.
	assign issue = cmd.scan && (addr_q != CNT_W'(NUM_BYTES));
	assign re    = cmd.rd_idx || issue;
	assign raddr = cmd.scan ? addr_q[BYTE_AW-1:0] : idx_byte;

	// Bytes not written since reset or the last fill read as the fill value.
	assign eff = vld_s1 ? rdata : {BYTE_W{fill_q}};

	assign is_rmw = (op_q == OP_SET) || (op_q == OP_CLEAR);
	assign we     = cmd.modify && in_range && is_rmw;
	assign wdata  = (op_q == OP_SET) ? (eff | (BYTE_W'(1) << idx_bit))
	                                 : (eff & CLEAR_MASKS[idx_bit]);

	assign want       = (op_q == OP_FIND_ONE);
	assign match_bits = want ? eff : ~eff;
	assign match      = |match_bits;

	always_comb begin
		first_k = '0;
		for (int k = BYTE_W - 1; k >= 0; k--) begin
			if (match_bits[k]) begin
				first_k = 3'(k);
			end
		end
	end

	assign pos = {b_s1, first_k};

	assign sts.scan_hit = chk_s1 && match;
	assign sts.scan_end = chk_s1 && (b_s1 == BYTE_AW'(NUM_BYTES - 1));

	bmff_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(NUM_BYTES),
		.AW   (BYTE_AW)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(idx_byte),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 1'b0;
			vld_q  <= '0;
			chk_s1 <= 1'b0;
		end else begin
			if (cmd.fill) begin
				fill_q <= fillv_q;
				vld_q  <= '0;
			end else if (we) begin
				vld_q[idx_byte] <= 1'b1;
			end
			if (cmd.load) begin
				chk_s1 <= 1'b0;
			end else begin
				chk_s1 <= issue;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q        <= operation;
			idx_q       <= bit_index;
			fillv_q     <= fill_value;
			addr_q      <= '0;
			res_bit_q   <= 1'b0;
			res_idx_q   <= '0;
			res_found_q <= 1'b0;
		end else begin
			if (issue) begin
				addr_q <= addr_q + CNT_W'(1);
			end
			if (cmd.modify && (op_q == OP_READ)) begin
				res_bit_q <= in_range && eff[idx_bit];
			end
			if (cmd.scan && sts.scan_hit) begin
				res_found_q <= 1'b1;
				res_idx_q   <= IDX_W'(pos);
			end
		end
		if (re) begin
			vld_s1 <= vld_q[raddr];
			b_s1   <= raddr;
		end
		if (cmd.out_load) begin
			bit_value_q   <= res_bit_q;
			found_index_q <= res_idx_q;
			found_q       <= res_found_q;
		end
	end

	assign bit_value   = bit_value_q;
	assign found_index = found_index_q;
	assign found       = found_q;

endmodule

FILE: bench/bitmap_with_find_first_checker.sv
// Checker for the bitmap find-first block: tracks the map and compares every result beat.
`timescale 1ns / 1ps

module bitmap_with_find_first_checker import bmff_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  logic [OP_W-1:0]  operation,
	input  logic [IDX_W-1:0] bit_index,
	input  logic             fill_value,
	input  logic             out_valid,
	input  logic             out_ready,
	input  logic             bit_value,
	input  logic [IDX_W-1:0] found_index,
	input  logic             found,
	output int               error_count,
	output int               results_checked,
	output int               outstanding
);

	typedef struct packed {
		logic             bit_value;
		logic [IDX_W-1:0] found_index;
		logic             found;
	} bmff_result_t;

	logic [BYTE_W-1:0] map_bytes [NUM_BYTES];
	bmff_result_t      pending_results [$];
	bmff_result_t      oldest;

	// Apply one request to the shadow map and return the result it yields.
	function automatic bmff_result_t apply_request(logic [OP_W-1:0] op,
			logic [IDX_W-1:0] idx, logic fv);
		bmff_result_t r;
		int           byte_sel;
		logic         want;
		r        = '0;
		byte_sel = int'(idx) / BYTE_W;
		case (op)
			OP_SET: begin
				if (byte_sel < NUM_BYTES)
					map_bytes[byte_sel][idx[2:0]] = 1'b1;
			end
			OP_CLEAR: begin
				if (byte_sel < NUM_BYTES)
					map_bytes[byte_sel] = map_bytes[byte_sel] & CLEAR_MASKS[idx[2:0]];
			end
			OP_READ: begin
				if (byte_sel < NUM_BYTES)
					r.bit_value = map_bytes[byte_sel][idx[2:0]];
			end
			OP_FIND_ONE, OP_FIND_ZERO: begin
				want = (op == OP_FIND_ONE);
				for (int b = 0; b < NUM_BYTES && !r.found; b++)
					for (int k = 0; k < BYTE_W && !r.found; k++)
						if (map_bytes[b][k] == want) begin
							r.found       = 1'b1;
							r.found_index = IDX_W'(b * BYTE_W + k);
						end
			end
			OP_FILL: begin
				for (int b = 0; b < NUM_BYTES; b++)
					map_bytes[b] = {BYTE_W{fv}};
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < NUM_BYTES; b++)
				map_bytes[b] = '0;
			pending_results.delete();
			outstanding <= 0;
		end else begin
			// Check the output beat before taking a new request at the same edge.
			if (out_valid && out_ready) begin
				results_checked++;
				if (pending_results.size() == 0) begin
					$error("result beat with no request pending");
					error_count++;
				end else begin
					oldest = pending_results.pop_front();
					if (bit_value !== oldest.bit_value) begin
						$error("bit_value: expected %0d, actual %0d", oldest.bit_value,
							bit_value);
						error_count++;
					end
					if (found_index !== oldest.found_index) begin
						$error("found_index: expected %0d, actual %0d", oldest.found_index,
							found_index);
						error_count++;
					end
					if (found !== oldest.found) begin
						$error("found: expected %0d, actual %0d", oldest.found, found);
						error_count++;
					end
				end
			end
			if (in_valid && in_ready)
				pending_results.push_back(apply_request(operation, bit_index, fill_value));
			outstanding <= pending_results.size();
		end
	end

endmodule

FILE: bench/bitmap_with_find_first_core_tb.sv
// Testbench top for the bitmap find-first block: clock, reset, request stimulus, verdict.
`timescale 1ns / 1ps

module bitmap_with_find_first_core_tb;
	import bmff_pkg::*;

	localparam logic [OP_W-1:0]  OP_UNUSED_LO = 3'd6;
	localparam logic [OP_W-1:0]  OP_UNUSED_HI = 3'd7;
	localparam logic [IDX_W-1:0] IDX_LAST     = IDX_W'(NUM_BYTES * BYTE_W - 1);
	localparam int               RANDOM_ITEMS = 600;

	logic             clk        = 1'b0;
	logic             arst_n     = 1'b0;
	logic             in_valid   = 1'b0;
	logic [OP_W-1:0]  operation  = OP_SET;
	logic [IDX_W-1:0] bit_index  = '0;
	logic             fill_value = 1'b0;
	logic             out_ready  = 1'b0;
	logic             in_ready;
	logic             out_valid;
	logic             bit_value;
	logic [IDX_W-1:0] found_index;
	logic             found;

	int error_count;
	int results_checked;
	int outstanding;
	int items_sent;
	int finds_sent;
	bit gaps_on = 1'b1;

	always #5 clk = ~clk;

	bitmap_with_find_first_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.bit_index   (bit_index),
		.fill_value  (fill_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.bit_value   (bit_value),
		.found_index (found_index),
		.found       (found)
	);

	bitmap_with_find_first_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.operation       (operation),
		.bit_index       (bit_index),
		.fill_value      (fill_value),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.bit_value       (bit_value),
		.found_index     (found_index),
		.found           (found),
		.error_count     (error_count),
		.results_checked (results_checked),
		.outstanding     (outstanding)
	);

	// Hold one request beat until the block takes it.
	task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
			input logic fv);
		while (gaps_on && $urandom_range(0, 99) < 27) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		operation  <= op;
		bit_index  <= idx;
		fill_value <= fv;
		do
			@(posedge clk);
		while (!in_ready);
		items_sent++;
		if (op == OP_FIND_ONE || op == OP_FIND_ZERO)
			finds_sent++;
	endtask

	// Receiver side: stall the result channel at random.
	initial begin
		forever begin
			@(posedge clk);
			out_ready <= arst_n && (!gaps_on || $urandom_range(0, 99) >= 27);
		end
	end

	initial begin
		logic [OP_W-1:0]  op;
		logic [IDX_W-1:0] idx;
		int               roll;
		int               focus;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Searches on an empty map find no one and the lowest zero.
		send_request(OP_FIND_ONE, '0, 1'b0);
		send_request(OP_FIND_ZERO, IDX_LAST, 1'b1);
		send_request(OP_SET, '0, 1'b0);
		send_request(OP_SET, IDX_LAST, 1'b1);
		send_request(OP_READ, '0, 1'b0);
		send_request(OP_READ, IDX_LAST, 1'b0);
		send_request(OP_READ, 9'd1, 1'b1);
		send_request(OP_FIND_ONE, '0, 1'b0);
		send_request(OP_CLEAR, '0, 1'b0);
		send_request(OP_FIND_ONE, '0, 1'b0);
		// Fill with one, then a search for zero must miss.
		send_request(OP_FILL, '0, 1'b1);
		send_request(OP_FIND_ZERO, '0, 1'b0);
		send_request(OP_FIND_ONE, '0, 1'b0);
		send_request(OP_READ, 9'd300, 1'b0);
		send_request(OP_CLEAR, IDX_LAST, 1'b0);
		send_request(OP_FIND_ZERO, '0, 1'b0);
		send_request(OP_CLEAR, 9'd256, 1'b1);
		send_request(OP_FIND_ZERO, '0, 1'b0);
		send_request(OP_FILL, IDX_LAST, 1'b0);
		send_request(OP_FIND_ONE, IDX_LAST, 1'b1);
		send_request(OP_UNUSED_LO, IDX_LAST, 1'b1);
		send_request(OP_UNUSED_HI, 9'($urandom_range(0, 511)), 1'b0);
		send_request(OP_SET, 9'd7, 1'b0);
		send_request(OP_SET, 9'd8, 1'b0);
		send_request(OP_FIND_ONE, '0, 1'b0);

		focus = $urandom_range(0, NUM_BYTES - 1);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			gaps_on = !(n >= 250 && n < 400);
			if ($urandom_range(0, 19) == 0)
				focus = $urandom_range(0, NUM_BYTES - 1);
			roll = $urandom_range(0, 99);
			if (roll < 24)
				op = OP_SET;
			else if (roll < 44)
				op = OP_CLEAR;
			else if (roll < 62)
				op = OP_READ;
			else if (roll < 76)
				op = OP_FIND_ONE;
			else if (roll < 90)
				op = OP_FIND_ZERO;
			else if (roll < 96)
				op = OP_FILL;
			else
				op = OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
			// Cluster half the indexes around a moving window so searches land deep.
			if ($urandom_range(0, 1))
				idx = 9'($urandom_range(0, 511));
			else
				idx = 9'((focus * BYTE_W + $urandom_range(0, 15)) % (NUM_BYTES * BYTE_W));
			send_request(op, idx, 1'($urandom_range(0, 1)));
		end
		in_valid <= 1'b0;
		gaps_on = 1'b1;

		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (NUM_BYTES + 8) @(posedge clk);

		$display("sent %0d requests, %0d of them searches; checked %0d result beats",
			items_sent, finds_sent, results_checked);
		if (error_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
